@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
// the macros expect clk_i in scope; ASSERT_CLK also expects rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/scb_pkg.sv @@
// scb_pkg: constants, codes and helpers of the size-class buffer cache
// used by the cache top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package scb_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int STACK_DEPTH = 16;
  localparam int ALIGN_BYTES = 64;
  localparam int ADDR_BITS   = 48;

  // field widths fixed by the interface
  localparam int OP_W     = 1;
  localparam int REQ_W    = 32;
  localparam int ADDR_W   = 48;
  localparam int BCLS_W   = 3;
  localparam int STAT_W   = 3;
  localparam int CAP_W    = 33;
  localparam int CNT_W    = 32;
  localparam int LIMIT_W  = 5;
  localparam int SIZE_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int IN_BITS   = REQ_W + ADDR_W + BCLS_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = ADDR_W + CAP_W + BCLS_W + 3 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // derived sizes
  localparam int KEEP_W  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
  localparam int LIM_W   = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
  localparam int RAM_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int RAM_AW  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int NUM_CFG_SIZES = 4;

  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((65'(1) << KEEP_W) - 65'(1));
  localparam logic [SIZE_W-1:0] CLASS_SIZE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_HIT         = 3'd0,
    STAT_CLASS_ALLOC = 3'd1,
    STAT_DIRECT      = 3'd2,
    STAT_CACHED      = 3'd3,
    STAT_FREED       = 3'd4,
    STAT_IGNORED     = 3'd5
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0 = 3'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  function automatic logic [SIZE_W-1:0] class_reset(input int idx);
    logic [SIZE_W-1:0] val;
    case (idx)
      0:       val = 32'd4096;
      1:       val = 32'd65536;
      2:       val = 32'd1048576;
      3:       val = 32'd16777216;
      default: val = CLASS_SIZE_MAX;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/scb_ram.sv @@
// scb_ram: generic single-clock ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module scb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/size_class_buffer_cache_top.sv @@
// size_class_buffer_cache_top: size-class buffer cache with per-class lifo stacks
// depends on scb_pkg and scb_ram
//
// usage:
//   s_axis carries one request per transaction: tuser is the operation
//   (acquire or release), tdata the request size, address and buffer class.
//   m_axis returns exactly one result per request: tuser is the status,
//   tdata the popped address, capacity, class and the three statistics counters.
//   the cfg port writes cache_limit (index 0) and class sizes (index 1..4);
//   the user must use it only while the block is idle, the block does not check.
// sequence:
//   after the accepting edge the block makes one read-modify-write pass over
//   the stack ram and fill counters, then the registered ram read lands in the
//   output register. tready is high only in idle, so no new request is taken
//   until the previous result has been loaded into the output register.
// reset:
//   fill counters and statistics clear at once, class sizes and the limit take
//   their defaults; the stack ram needs no clearing since only pushed entries
//   are ever popped.
// stall:
//   while m_axis_tready_i is low the result holds; one further request may be
//   accepted and worked up to the output stage, where it waits for the slot.
`timescale 1ns / 1ps
`default_nettype none

module size_class_buffer_cache_top
  import scb_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // request channel
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // request_bytes[31:0], buffer_addr[79:32], buffer_class[82:80], zero pad
  input  wire logic [IN_DATA_W-1:0]    s_axis_tdata_i,
  // op[0]
  input  wire logic [OP_W-1:0]         s_axis_tuser_i,
  // result channel
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  // out_addr[47:0], out_capacity[80:48], out_class[83:81],
  // system_alloc_count[115:84], hit_count[147:116], return_count[179:148], zero pad
  output logic      [OUT_DATA_W-1:0]   m_axis_tdata_o,
  // status[2:0]
  output logic      [STAT_W-1:0]       m_axis_tuser_o,
  // configuration writes
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0]    cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  typedef struct packed {
    logic                op;
    logic [REQ_W-1:0]    req;
    logic [ADDR_W-1:0]   addr;
    logic [BCLS_W-1:0]   bcls;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [CAP_W-1:0]    cap;
    logic [BCLS_W-1:0]   ocls;
    logic                pop;
  } res_t;

  state_e state_q, state_d;
  req_t   req_q;
  res_t   res_q, res_d;

  logic [LIMIT_W-1:0] limit_q;
  logic [SIZE_W-1:0]  size_q [NUM_CLASSES];
  logic [FILL_W-1:0]  fill_q [NUM_CLASSES];
  logic [CNT_W-1:0]   alloc_cnt_q, hit_cnt_q, ret_cnt_q;

  logic               out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [STAT_W-1:0]  out_user_q;

  logic               in_fire, out_load, exec_en;

  // execute-stage signals
  logic [NUM_CLASSES-1:0] fits;
  logic                   found;
  logic [CLS_W-1:0]       cls, sel_idx, bc_idx;
  logic [FILL_W-1:0]      fill_cur, fill_new, stk_pos;
  logic                   fill_upd;
  logic [LIM_W-1:0]       lim;
  logic [ADDR_W-1:0]      addr_m;
  logic [CAP_W-1:0]       align_sum, align_cap;
  logic                   ram_we, ram_re;
  logic [RAM_AW-1:0]      ram_addr;
  logic [KEEP_W-1:0]      ram_rdata;
  logic                   inc_alloc, inc_hit, inc_ret;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign exec_en  = (state_q == ST_EXEC);
  assign out_load = (state_q == ST_RESP) & (~out_valid_q | m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire)  state_d = ST_EXEC;
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // class select
  always_comb begin
    found = 1'b0;
    cls   = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      fits[i] = ({1'b0, req_q.req} <= {1'b0, size_q[i]});
    end
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (fits[i]) begin
        found = 1'b1;
        cls   = CLS_W'(i);
      end
    end
  end

  assign bc_idx    = req_q.bcls[CLS_W-1:0];
  assign sel_idx   = (req_q.op == OP_RELEASE) ? bc_idx : cls;
  assign fill_cur  = fill_q[sel_idx];
  assign addr_m    = req_q.addr & ADDR_MASK;
  assign lim       = (LIM_W'(limit_q) < LIM_W'(STACK_DEPTH)) ? LIM_W'(limit_q)
                                                             : LIM_W'(STACK_DEPTH);
  assign align_sum = {1'b0, req_q.req} + CAP_W'(ALIGN_BYTES - 1);
  assign align_cap = CAP_W'((align_sum / ALIGN_BYTES) * ALIGN_BYTES);

  always_comb begin
    res_d     = '0;
    fill_upd  = 1'b0;
    fill_new  = fill_cur;
    stk_pos   = fill_cur;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    inc_alloc = 1'b0;
    inc_hit   = 1'b0;
    inc_ret   = 1'b0;
    if (req_q.op == OP_ACQUIRE) begin
      if (found) begin
        res_d.cap  = {1'b0, size_q[cls]};
        res_d.ocls = BCLS_W'(cls);
        if (fill_cur != '0) begin
          stk_pos      = fill_cur - FILL_W'(1);
          fill_new     = stk_pos;
          fill_upd     = 1'b1;
          ram_re       = exec_en;
          inc_hit      = 1'b1;
          res_d.pop    = 1'b1;
          res_d.status = STAT_HIT;
        end else begin
          inc_alloc    = 1'b1;
          res_d.status = STAT_CLASS_ALLOC;
        end
      end else begin
        res_d.cap    = align_cap;
        res_d.ocls   = BCLS_W'(NUM_CLASSES);
        inc_alloc    = 1'b1;
        res_d.status = STAT_DIRECT;
      end
    end else begin
      if (addr_m == '0) begin
        res_d.status = STAT_IGNORED;
      end else if ({1'b0, req_q.bcls} >= (BCLS_W + 1)'(NUM_CLASSES)) begin
        res_d.status = STAT_FREED;
      end else if (LIM_W'(fill_cur) < lim) begin
        fill_new     = fill_cur + FILL_W'(1);
        fill_upd     = 1'b1;
        ram_we       = exec_en;
        inc_ret      = 1'b1;
        res_d.status = STAT_CACHED;
      end else begin
        res_d.status = STAT_FREED;
      end
    end
  end

  assign ram_addr = RAM_AW'(RAM_AW'(sel_idx) * RAM_AW'(STACK_DEPTH) + RAM_AW'(stk_pos));

  scb_ram #(
    .WIDTH (KEEP_W),
    .DEPTH (RAM_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (addr_m[KEEP_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LIMIT_RESET;
      alloc_cnt_q <= '0;
      hit_cnt_q   <= '0;
      ret_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        size_q[i] <= class_reset(i);
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == CFG_LIMIT) begin
        limit_q <= cfg_wdata_i[LIMIT_W-1:0];
      end
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (i < NUM_CFG_SIZES && cfg_we_i && cfg_idx_i == CFG_SIZE0 + CFG_IDX_W'(i)) begin
          size_q[i] <= cfg_wdata_i;
        end
      end
      if (exec_en) begin
        if (fill_upd) begin
          fill_q[sel_idx] <= fill_new;
        end
        if (inc_alloc) alloc_cnt_q <= alloc_cnt_q + CNT_W'(1);
        if (inc_hit)   hit_cnt_q   <= hit_cnt_q + CNT_W'(1);
        if (inc_ret)   ret_cnt_q   <= ret_cnt_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.op   <= s_axis_tuser_i[0];
      req_q.req  <= s_axis_tdata_i[REQ_W-1:0];
      req_q.addr <= s_axis_tdata_i[REQ_W +: ADDR_W];
      req_q.bcls <= s_axis_tdata_i[REQ_W + ADDR_W +: BCLS_W];
    end
    if (exec_en) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_user_q <= res_q.status;
      out_data_q <= OUT_DATA_W'({ret_cnt_q, hit_cnt_q, alloc_cnt_q, res_q.ocls, res_q.cap,
                                 res_q.pop ? ADDR_W'(ram_rdata) : ADDR_W'(0)});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

@@ hw/rtl/scb_checker.sv @@
// scb_checker: port-level assertions on the size-class buffer cache
// depends on scb_pkg and assert_macros.svh; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module scb_checker
  import scb_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic [STAT_W-1:0]     m_axis_tuser_o
);

  logic rel_status;
  logic out_stall;
  logic [OUT_DATA_W+STAT_W-1:0] out_word;

  assign rel_status = (m_axis_tuser_o == STAT_CACHED) || (m_axis_tuser_o == STAT_FREED)
                      || (m_axis_tuser_o == STAT_IGNORED);
  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word   = {m_axis_tuser_o, m_axis_tdata_o};

  `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(out_word), "result changed")

  `ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o, "result valid during reset")

  `ASSERT_CLK(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "busy")

  `ASSERT_CLK(a_status_range, m_axis_tvalid_o |-> m_axis_tuser_o <= STAT_IGNORED, "bad status")

  `ASSERT_CLK(a_release_no_cap, m_axis_tvalid_o && rel_status |-> m_axis_tdata_o[80:0] == '0, "cap")

endmodule

bind size_class_buffer_cache_top scb_checker u_scb_checker (.*);

`default_nettype wire
